### rtl/brsp_pkg.sv
`default_nettype none

package brsp_pkg;

  // Field codes; the phase register holds the code of the field being parsed.
  typedef enum logic [4:0] {
    PH_VERSION     = 5'd0,
    PH_PREV_HASH   = 5'd1,
    PH_MERKLE      = 5'd2,
    PH_FP_HASH     = 5'd3,
    PH_HDR_HASH    = 5'd4,
    PH_TIMESTAMP   = 5'd5,
    PH_SONG_FLAG   = 5'd6,
    PH_AUDIO_FMT   = 5'd7,
    PH_SONG_HASH   = 5'd8,
    PH_FP_LEN      = 5'd9,
    PH_FP_DATA     = 5'd10,
    PH_DURATION    = 5'd11,
    PH_TITLE_LEN   = 5'd12,
    PH_TITLE_DATA  = 5'd13,
    PH_ARTIST_LEN  = 5'd14,
    PH_ARTIST_DATA = 5'd15,
    PH_ARTIST_ADDR = 5'd16,
    PH_GENRE_LEN   = 5'd17,
    PH_GENRE_DATA  = 5'd18,
    PH_ALBUM_LEN   = 5'd19,
    PH_ALBUM_DATA  = 5'd20,
    PH_YEAR        = 5'd21,
    PH_TRACK       = 5'd22,
    PH_SPLIT_CNT   = 5'd23,
    PH_SPLIT_ADDR  = 5'd24,
    PH_SPLIT_BPS   = 5'd25,
    PH_SEP         = 5'd26,
    PH_TX_CNT      = 5'd27,
    PH_TX_LEN      = 5'd28,
    PH_TX_DATA     = 5'd29,
    PH_DONE        = 5'd30
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_OK      = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_SEP_ERR = 2'd3
  } status_e;

  // Register index, taken from paddr[2]
  localparam logic REG_SEP_VALUE = 1'b0;
  localparam logic REG_SEP_COUNT = 1'b1;

  localparam int unsigned HashBytes = 32;
  localparam int unsigned AddrBytes = 20;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] bytes_left;
    logic [31:0] len_acc;
    logic [7:0]  splits_left;
    logic [31:0] trans_left;
    status_e     status;
    logic        first;
  } parse_st_t;

  typedef struct packed {
    logic [7:0] byte_out;
    phase_e     field_tag;
    logic       field_start;
    status_e    parse_status;
    logic       buffer_done;
  } result_t;

  localparam parse_st_t PARSE_RESET = '{
    phase:       PH_VERSION,
    bytes_left:  32'd4,
    len_acc:     32'd0,
    splits_left: 8'd0,
    trans_left:  32'd0,
    status:      ST_RUN,
    first:       1'b1
  };

  // Length of a fixed-size field; variable fields and the separator return 0
  function automatic logic [7:0] field_len(phase_e p);
    logic [7:0] len;
    case (p)
      PH_VERSION:     len = 8'd4;
      PH_PREV_HASH:   len = 8'(HashBytes);
      PH_MERKLE:      len = 8'(HashBytes);
      PH_FP_HASH:     len = 8'(HashBytes);
      PH_HDR_HASH:    len = 8'(HashBytes);
      PH_TIMESTAMP:   len = 8'd8;
      PH_SONG_FLAG:   len = 8'd1;
      PH_AUDIO_FMT:   len = 8'd1;
      PH_SONG_HASH:   len = 8'(HashBytes);
      PH_FP_LEN:      len = 8'd2;
      PH_DURATION:    len = 8'd4;
      PH_TITLE_LEN:   len = 8'd2;
      PH_ARTIST_LEN:  len = 8'd2;
      PH_ARTIST_ADDR: len = 8'(AddrBytes);
      PH_GENRE_LEN:   len = 8'd2;
      PH_ALBUM_LEN:   len = 8'd2;
      PH_YEAR:        len = 8'd2;
      PH_TRACK:       len = 8'd2;
      PH_SPLIT_CNT:   len = 8'd1;
      PH_SPLIT_ADDR:  len = 8'(AddrBytes);
      PH_SPLIT_BPS:   len = 8'd2;
      PH_TX_CNT:      len = 8'd4;
      PH_TX_LEN:      len = 8'd4;
      default:        len = 8'd0;
    endcase
    return len;
  endfunction

  function automatic logic is_len_field(phase_e p);
    return (p == PH_FP_LEN) || (p == PH_TITLE_LEN) || (p == PH_ARTIST_LEN) ||
           (p == PH_GENRE_LEN) || (p == PH_ALBUM_LEN) || (p == PH_TX_CNT) ||
           (p == PH_TX_LEN);
  endfunction

  function automatic logic is_var_field(phase_e p);
    return (p == PH_FP_DATA) || (p == PH_TITLE_DATA) || (p == PH_ARTIST_DATA) ||
           (p == PH_GENRE_DATA) || (p == PH_ALBUM_DATA) || (p == PH_TX_DATA);
  endfunction

endpackage

`default_nettype wire

### rtl/brsp_step.sv
`default_nettype none

module brsp_step import brsp_pkg::*; (
  input  parse_st_t  state_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_buffer_i,
  input  logic [7:0] sep_value_i,
  input  logic [7:0] sep_count_i,
  output parse_st_t  state_o,
  output result_t    result_o
);

  parse_st_t   nxt;

  always_comb begin : next_state
    logic [31:0] base;
    logic [1:0]  pos;
    logic [31:0] acc_n;
    logic [31:0] bl_dec;
    logic [7:0]  split_dec;
    logic [31:0] trans_dec;
    phase_e      np;
    phase_e      np2;
    logic [31:0] len;
    logic [31:0] len2;

    nxt       = state_i;
    base      = state_i.first ? 32'd0 : state_i.len_acc;
    pos       = 2'(field_len(state_i.phase) - {6'd0, state_i.bytes_left[1:0]});
    acc_n     = state_i.len_acc;
    bl_dec    = state_i.bytes_left - 32'd1;
    split_dec = state_i.splits_left - 8'd1;
    np        = PH_DONE;
    np2       = PH_DONE;
    len       = 32'd0;
    len2      = 32'd0;
    trans_dec = 32'd0;

    // little-endian length: place this byte at its position
    if (is_len_field(state_i.phase)) begin
      acc_n = base | ({24'd0, data_byte_i} << {pos, 3'b000});
    end
    nxt.len_acc = acc_n;

    if (state_i.phase != PH_DONE) begin
      nxt.first = 1'b0;
      if (state_i.phase == PH_SEP && data_byte_i != sep_value_i) begin
        nxt.status     = ST_SEP_ERR;
        nxt.phase      = PH_DONE;
        nxt.bytes_left = 32'd0;
        nxt.first      = 1'b1;
      end else begin
        nxt.bytes_left = bl_dec;
        if (bl_dec == 32'd0) begin
          // pick the following field
          case (state_i.phase)
            PH_SONG_FLAG: begin
              np = (data_byte_i != 8'd0) ? PH_AUDIO_FMT : PH_SEP;
            end
            PH_SPLIT_CNT: begin
              nxt.splits_left = data_byte_i;
              np = (data_byte_i != 8'd0) ? PH_SPLIT_ADDR : PH_SEP;
            end
            PH_SPLIT_BPS: begin
              nxt.splits_left = split_dec;
              np = (split_dec != 8'd0) ? PH_SPLIT_ADDR : PH_SEP;
            end
            PH_TX_CNT: begin
              nxt.trans_left = acc_n;
              if (acc_n == 32'd0) begin
                nxt.status = ST_OK;
                np = PH_DONE;
              end else begin
                np = PH_TX_LEN;
              end
            end
            PH_TX_DATA: begin
              nxt.trans_left = state_i.trans_left - 32'd1;
              if (nxt.trans_left == 32'd0) begin
                nxt.status = ST_OK;
                np = PH_DONE;
              end else begin
                np = PH_TX_LEN;
              end
            end
            default: begin
              np = phase_e'(state_i.phase + 5'd1);
            end
          endcase

          // length of the entered field
          if (np == PH_SEP) begin
            len = {24'd0, sep_count_i};
          end else if (is_var_field(np)) begin
            len = acc_n;
          end else begin
            len = {24'd0, field_len(np)};
          end

          // skip an empty field; what follows always has a fixed length
          np2  = np;
          len2 = len;
          if (np != PH_DONE && len == 32'd0) begin
            if (np == PH_SEP) begin
              np2 = PH_TX_CNT;
            end else if (np == PH_TX_DATA) begin
              trans_dec      = nxt.trans_left - 32'd1;
              nxt.trans_left = trans_dec;
              if (trans_dec == 32'd0) begin
                nxt.status = ST_OK;
                np2 = PH_DONE;
              end else begin
                np2 = PH_TX_LEN;
              end
            end else begin
              np2 = phase_e'(np + 5'd1);
            end
            len2 = {24'd0, field_len(np2)};
          end

          nxt.phase      = np2;
          nxt.bytes_left = len2;
          nxt.first      = 1'b1;
        end
      end
    end

    state_o = end_of_buffer_i ? PARSE_RESET : nxt;
  end

  always_comb begin : outputs
    result_o.byte_out     = data_byte_i;
    result_o.field_tag    = state_i.phase;
    result_o.field_start  = (state_i.phase != PH_DONE) && state_i.first;
    result_o.parse_status = nxt.status;
    result_o.buffer_done  = end_of_buffer_i;
    if (end_of_buffer_i && nxt.status == ST_RUN) begin
      result_o.parse_status = ST_TRUNC;
    end
  end

endmodule

`default_nettype wire

### rtl/block_record_stream_parser.sv
`default_nettype none

// Channel   Direction  Content
// s_axis    in         tdata[7:0] data_byte, tlast end_of_buffer
// m_axis    out        tdata[7:0] byte_out, [9:8] parse_status;
//                      tuser[4:0] field_tag, [5] field_start; tlast buffer_done
// apb       in/out     0x0 separator_value, 0x4 separator_count
//
// One byte per cycle: the parse step is one state update plus a 32-bit
// decrement and compare, settled between the state register and the
// output register, so a byte is taken every cycle the output is free.
// m_axis_tvalid is registered and rises in the cycle after a byte is accepted.
// Reset clears parse state and sets separator_value 0, separator_count 4.
// A stalled output holds its item; input is taken again when it drains.
module block_record_stream_parser import brsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // data_byte [7:0]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // byte_out [7:0], parse_status [9:8], zero [15:10]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  // field_tag [4:0], field_start [5], zero [7:6]
  output logic [7:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  parse_st_t  state_q, state_d;
  result_t    res_q, res_d;
  logic       valid_q;
  logic [7:0] sep_value_q;
  logic [7:0] sep_count_q;
  logic       accept;
  logic       cfg_wr;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite;

  brsp_step u_step (
    .state_i         (state_q),
    .data_byte_i     (s_axis_tdata),
    .end_of_buffer_i (s_axis_tlast),
    .sep_value_i     (sep_value_q),
    .sep_count_i     (sep_count_q),
    .state_o         (state_d),
    .result_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PARSE_RESET;
      valid_q     <= 1'b0;
      sep_value_q <= 8'd0;
      sep_count_q <= 8'd4;
    end else begin
      if (accept) begin
        state_q <= state_d;
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[2])
          REG_SEP_VALUE: sep_value_q <= pwdata[7:0];
          REG_SEP_COUNT: sep_count_q <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SEP_VALUE: prdata = {24'd0, sep_value_q};
      REG_SEP_COUNT: prdata = {24'd0, sep_count_q};
      default:       prdata = 32'd0;
    endcase
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {6'd0, res_q.parse_status, res_q.byte_out};
  assign m_axis_tuser  = {2'd0, res_q.field_start, res_q.field_tag};
  assign m_axis_tlast  = res_q.buffer_done;

endmodule

`default_nettype wire
